@@ sv/selective_repeat_receiver_core_assert.svh @@
// assertion macros shared by the receiver core
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication
`define SRR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/srr_pkg.sv @@
`timescale 1ns / 1ps
package srr_pkg;

  localparam int SEQ_RANGE      = 16;
  localparam int MAX_WINDOW     = 8;
  localparam int SEQ_W          = $clog2(SEQ_RANGE);
  localparam int WIN_CAP        = (MAX_WINDOW < SEQ_RANGE / 2) ? MAX_WINDOW : SEQ_RANGE / 2;
  localparam int CMP_W          = (SEQ_W + 1 > 4) ? SEQ_W + 1 : 4;
  localparam int STEP_W         = $clog2(MAX_WINDOW + 1);
  localparam int ACK_CHECK_BASE = 959;
  localparam int SLOT_W         = 160;
  localparam logic [3:0] WIN_RESET = 4'd6;

  typedef struct packed {
    logic signed [31:0] seq_num;
    logic signed [31:0] ack_num;
    logic signed [31:0] check_value;
    logic [63:0]        data_lo;
    logic [63:0]        data_mid;
    logic [31:0]        data_hi;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ack_number;
    logic [10:0] ack_check;
    logic [63:0] out_lo;
    logic [63:0] out_mid;
    logic [31:0] out_hi;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic done;
    logic match;
  } csum_stat_t;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

endpackage

@@ sv/srr_ram.sv @@
`timescale 1ns / 1ps
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/srr_csum.sv @@
`timescale 1ns / 1ps
module srr_csum import srr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  in_item_t   in_item,
  input  in_item_t   held,
  output csum_stat_t stat
);

  logic [1:0]  cnt;
  logic        active;
  logic        fin;
  logic [31:0] acc;
  logic [63:0] word;

  function automatic logic [31:0] byte_sum(input logic [63:0] w);
    logic [11:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + {{4{w[8*i+7]}}, w[8*i +: 8]};
    end
    return {{20{s[11]}}, s};
  endfunction

  always_comb begin
    case (cnt)
      2'd1:    word = held.data_lo;
      2'd2:    word = held.data_mid;
      default: word = {32'd0, held.data_hi};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      active <= 1'b0;
      fin    <= 1'b0;
    end else begin
      if (go) begin
        cnt    <= 2'd1;
        active <= 1'b1;
        fin    <= 1'b0;
      end else if (active) begin
        cnt <= cnt + 2'd1;
        fin <= (cnt == 2'd3);
        if (cnt == 2'd3) begin
          active <= 1'b0;
        end
      end else begin
        fin <= 1'b0;
      end
    end
  end

  // header words first, then one payload word a cycle
  always_ff @(posedge clk) begin
    if (go) begin
      acc <= in_item.seq_num + in_item.ack_num;
    end else if (active) begin
      acc <= acc + byte_sum(word);
    end
  end

  assign stat.done  = fin;
  assign stat.match = (acc == held.check_value);

endmodule

@@ sv/selective_repeat_receiver_core.sv @@
`timescale 1ns / 1ps
// Selective-repeat receiver. A packet is taken when start is high and busy low.
// The checksum runs in S_SUM (header, then one payload word a cycle), the
// window check in S_CHECK after it, so a corrupt packet drops busy from S_SUM
// and one that is then dropped or only acknowledged drops it from S_CHECK. A
// stored packet that frees a run of n slots gives the ack, S_RD opens the slot
// RAM read, then one delivered word per cycle comes from its read port (S_OUT).
// Results appear on result for a single cycle with result_valid and cannot be
// held off; the ack comes first and last marks the final word of each packet.
// The slot store needs no clearing pass: per-slot full flags are cleared at reset.
`include "selective_repeat_receiver_core_assert.svh"
module selective_repeat_receiver_core import srr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_item_t   item,
  output logic       result_valid,
  output out_item_t  result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_CHECK = 5'b00100,
    S_RD    = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                 state, state_next;
  in_item_t               itm;
  logic [3:0]             window_size;
  logic [SEQ_W-1:0]       expected, expected_next, exp_inc;
  logic [SEQ_RANGE-1:0]   slot_full, slot_full_next;
  logic [STEP_W-1:0]      steps, steps_next;
  logic                   result_valid_next;
  out_item_t              result_next;
  csum_stat_t             cs;
  logic                   accept;
  logic                   ram_we;
  logic [SEQ_W-1:0]       ram_raddr;
  logic [SLOT_W-1:0]      ram_rdata;
  logic [SEQ_W-1:0]       seq_idx;
  logic                   seq_ok;
  logic [CMP_W-1:0]       ws, win, gap;
  logic                   in_win, low_win, more;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  srr_csum u_csum (
    .clk     (clk),
    .rst     (rst),
    .go      (accept),
    .in_item (item),
    .held    (itm),
    .stat    (cs)
  );

  srr_ram #(.WIDTH(SLOT_W), .DEPTH(SEQ_RANGE)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seq_idx),
    .wdata ({itm.data_hi, itm.data_mid, itm.data_lo}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign seq_idx = itm.seq_num[SEQ_W-1:0];
  assign seq_ok  = (unsigned'(itm.seq_num) < 32'(SEQ_RANGE));
  assign exp_inc = (expected == SEQ_W'(SEQ_RANGE - 1)) ? '0 : expected + 1'b1;

  // window clamp: zero acts as one, large values fall to the cap
  assign ws  = CMP_W'(window_size);
  assign win = (ws == '0) ? CMP_W'(1) : ((ws > CMP_W'(WIN_CAP)) ? CMP_W'(WIN_CAP) : ws);

  assign gap = (seq_idx >= expected) ? CMP_W'(seq_idx) - CMP_W'(expected)
                                     : CMP_W'(seq_idx) + CMP_W'(SEQ_RANGE) - CMP_W'(expected);
  assign in_win  = (gap < win);
  assign low_win = (gap >= CMP_W'(SEQ_RANGE) - win);

  assign more      = ((steps + 1'b1) < STEP_W'(MAX_WINDOW)) && slot_full[exp_inc];
  assign ram_raddr = (state == S_OUT) ? exp_inc : expected;

  always_comb begin
    state_next        = state;
    expected_next     = expected;
    slot_full_next    = slot_full;
    steps_next        = steps;
    ram_we            = 1'b0;
    result_valid_next = 1'b0;
    result_next       = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (cs.done) begin
          state_next = cs.match ? S_CHECK : S_IDLE;
        end
      end
      S_CHECK: begin
        state_next             = S_IDLE;
        result_next.kind       = KIND_ACK;
        result_next.ack_number = 8'(seq_idx);
        result_next.ack_check  = 11'(seq_idx) + 11'(ACK_CHECK_BASE);
        result_next.last       = 1'b1;
        if (seq_ok && in_win) begin
          result_valid_next = 1'b1;
          if (!slot_full[seq_idx]) begin
            ram_we                  = 1'b1;
            slot_full_next[seq_idx] = 1'b1;
            // a delivery follows if the expected slot is now filled
            if ((seq_idx == expected) || slot_full[expected]) begin
              result_next.last = 1'b0;
              state_next       = S_RD;
            end
          end
        end else if (seq_ok && low_win) begin
          result_valid_next = 1'b1;
        end
      end
      S_RD: begin
        steps_next = '0;
        state_next = S_OUT;
      end
      S_OUT: begin
        result_valid_next        = 1'b1;
        result_next.kind         = KIND_DELIVER;
        result_next.out_lo       = ram_rdata[63:0];
        result_next.out_mid      = ram_rdata[127:64];
        result_next.out_hi       = ram_rdata[159:128];
        result_next.last         = !more;
        slot_full_next[expected] = 1'b0;
        expected_next            = exp_inc;
        steps_next               = steps + 1'b1;
        state_next               = more ? S_OUT : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      expected     <= '0;
      slot_full    <= '0;
      steps        <= '0;
      window_size  <= WIN_RESET;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      expected     <= expected_next;
      slot_full    <= slot_full_next;
      steps        <= steps_next;
      result_valid <= result_valid_next;
      if (cfg_valid && cfg_ready) begin
        window_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (accept) begin
      itm <= item;
    end
  end

  `SRR_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted word did not raise busy")
  `SRR_ASSERT_NOW(a_more_follows, clk, rst, result_valid && !result.last, busy,
                  "non-final result with core idle")
  `SRR_ASSERT_NOW(a_full_bound, clk, rst, 1'b1, $countones(slot_full) <= WIN_CAP,
                  "more filled slots than the window allows")

endmodule
